// ----- hdl/lmi_pkg.sv -----
package lmi_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int COORD_BITS_DEF = 16;
    localparam int DUR_MS_BITS    = 32;
    localparam int US_PER_MS      = 1000;
    localparam int DUR_US_BITS    = DUR_MS_BITS + $clog2(US_PER_MS);
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int MODE_BITS      = 2;

    localparam logic [MODE_BITS-1:0] MODE_START = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_STOP  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_START_X  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_Y  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_END_X    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_END_Y    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DURATION = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ----- hdl/lmi_div.sv -----
module lmi_div
    import lmi_pkg::*;
#(
    parameter int WIDTH = TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic [WIDTH-1:0] o_quo,
    output t_div_sts         o_sts
);

    localparam int CNT_BITS = $clog2(WIDTH);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(WIDTH - 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [WIDTH-1:0]    r_rem;
    logic [WIDTH-1:0]    r_quo;
    logic [WIDTH-1:0]    r_den;
    logic [WIDTH:0]      trial;
    logic                fits;

    assign trial = {r_rem, r_quo[WIDTH-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? WIDTH'(trial - {1'b0, r_den}) : trial[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], fits};
        end
    end

    assign o_quo      = r_quo;
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ----- hdl/linear_move_interpolator.sv -----
// Start, stop and idle items give their beat in the cycle after acceptance.
// A running tick gives its beat once its divisions are done, one at a time on
// the one shared divider; a tick past the duration goes through ST_CMP and
// ST_OUT instead. One item is taken at a time. Synchronous active-low reset
// clears the registers, the move state and the output beat.
module linear_move_interpolator
    import lmi_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // now_us, zero padded to whole bytes
    input  logic [((TIME_BITS+7)/8)*8-1:0] i_s_tdata,
    // mode
    input  logic [MODE_BITS-1:0]         i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // pos_x, then pos_y, zero padded to whole bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_tdata,
    // pos_valid
    output logic                         o_m_tuser,
    // done_res
    output logic                         o_m_tlast
);

    localparam int OUT_BITS = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int DIV_BITS = (TIME_BITS > DUR_US_BITS) ? TIME_BITS : DUR_US_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_DIST = 3'd2;
    localparam logic [2:0] ST_TPP  = 3'd3;
    localparam logic [2:0] ST_CUR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             r_state;
    logic                   r_axis;
    logic                   r_neg;
    logic                   r_running;
    logic [TIME_BITS-1:0]   r_begin;
    logic [TIME_BITS-1:0]   r_elapsed;
    logic [DUR_US_BITS-1:0] r_dur_us;
    logic [COORD_BITS-1:0]  r_start_x, r_start_y, r_end_x, r_end_y;
    logic [DUR_MS_BITS-1:0] r_dur_ms;
    logic [COORD_BITS-1:0]  r_px, r_py;
    logic                   r_ov, r_ou, r_ol;
    logic [COORD_BITS-1:0]  r_ox, r_oy;

    logic                   s_acc;
    logic                   out_free;
    logic [MODE_BITS-1:0]   mode;
    logic [TIME_BITS-1:0]   now;
    logic [COORD_BITS-1:0]  ax_s, ax_e, pos_new;
    logic [COORD_BITS:0]    delta, mag;
    logic [DUR_US_BITS-1:0] dur_ms_ext;
    logic                   div_start;
    logic [DIV_BITS-1:0]    div_num, div_den, div_quo;
    t_div_sts               div_sts;
    logic                   pos_load;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ov || i_m_tready;
    assign o_s_tready  = (r_state == ST_IDLE) && out_free;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign mode        = i_s_tuser;
    assign now         = i_s_tdata[TIME_BITS-1:0];
    assign dur_ms_ext  = DUR_US_BITS'(r_dur_ms);

    assign ax_s  = r_axis ? r_start_y : r_start_x;
    assign ax_e  = r_axis ? r_end_y : r_end_x;
    assign delta = {ax_e[COORD_BITS-1], ax_e} - {ax_s[COORD_BITS-1], ax_s};
    assign mag   = delta[COORD_BITS] ? (COORD_BITS+1)'(-delta) : delta;

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_BITS'(r_dur_us);
        div_den   = DIV_BITS'(mag);
        pos_load  = 1'b0;
        pos_new   = ax_s;
        unique case (r_state)
            ST_DIST: begin
                if (mag == '0) begin
                    pos_load = 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            ST_TPP: begin
                div_num = DIV_BITS'(r_elapsed);
                div_den = div_quo;
                if (div_sts.done) begin
                    if (div_quo == '0) begin
                        pos_load = 1'b1;
                        pos_new  = ax_e;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_CUR: begin
                if (div_sts.done) begin
                    pos_load = 1'b1;
                    pos_new  = r_neg ? ax_s - div_quo[COORD_BITS-1:0]
                                     : ax_s + div_quo[COORD_BITS-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    lmi_div #(
        .WIDTH (DIV_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_sts   (div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_dur_ms  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_START_X:  r_start_x <= i_cfg_data[COORD_BITS-1:0];
                REG_START_Y:  r_start_y <= i_cfg_data[COORD_BITS-1:0];
                REG_END_X:    r_end_x   <= i_cfg_data[COORD_BITS-1:0];
                REG_END_Y:    r_end_y   <= i_cfg_data[COORD_BITS-1:0];
                REG_DURATION: r_dur_ms  <= i_cfg_data[DUR_MS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_axis    <= 1'b0;
            r_running <= 1'b0;
            r_begin   <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_ov <= 1'b1;
                        r_ou <= 1'b0;
                        r_ox <= '0;
                        r_oy <= '0;
                        unique case (mode)
                            MODE_START: begin
                                r_running <= 1'b1;
                                r_begin   <= now;
                                r_ou      <= 1'b1;
                                r_ox      <= r_start_x;
                                r_oy      <= r_start_y;
                                r_ol      <= 1'b0;
                            end
                            MODE_STOP: begin
                                r_running <= 1'b0;
                                r_ol      <= 1'b1;
                            end
                            MODE_TICK: begin
                                if (r_running) begin
                                    r_ov      <= 1'b0;
                                    r_elapsed <= now - r_begin;
                                    // 1000 = 1024 - 16 - 8.
                                    r_dur_us  <= (dur_ms_ext << 10) - (dur_ms_ext << 4)
                                                 - (dur_ms_ext << 3);
                                    r_state   <= ST_CMP;
                                end else begin
                                    r_ol <= 1'b1;
                                end
                            end
                            default: begin
                                r_ol <= !r_running;
                            end
                        endcase
                    end
                end
                ST_CMP: begin
                    if (DIV_BITS'(r_elapsed) >= DIV_BITS'(r_dur_us)) begin
                        r_px      <= r_end_x;
                        r_py      <= r_end_y;
                        r_running <= 1'b0;
                        r_state   <= ST_OUT;
                    end else begin
                        r_axis  <= 1'b0;
                        r_state <= ST_DIST;
                    end
                end
                ST_DIST: begin
                    r_neg <= delta[COORD_BITS];
                    if (div_start) begin
                        r_state <= ST_TPP;
                    end
                end
                ST_TPP: begin
                    if (div_start) begin
                        r_state <= ST_CUR;
                    end
                end
                ST_CUR: begin
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ou    <= 1'b1;
                        r_ox    <= r_px;
                        r_oy    <= r_py;
                        r_ol    <= !r_running;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (pos_load) begin
                if (r_axis) begin
                    r_py    <= pos_new;
                    r_state <= ST_OUT;
                end else begin
                    r_px    <= pos_new;
                    r_axis  <= 1'b1;
                    r_state <= ST_DIST;
                end
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ou;
    assign o_m_tlast  = r_ol;
    assign o_m_tdata  = OUT_BITS'({r_oy, r_ox});

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import lmi_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        bit        valid;
        bit [15:0] x;
        bit [15:0] y;
        bit        done;
    } t_pos_beat;

    class move_scoreboard;
        bit [15:0] start_x, start_y, end_x, end_y;
        bit [31:0] dur_ms;
        bit        running;
        bit [47:0] t_begin;
        t_pos_beat pending[$];
        int        errors;

        function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_START_X:  start_x = val[15:0];
                REG_START_Y:  start_y = val[15:0];
                REG_END_X:    end_x = val[15:0];
                REG_END_Y:    end_y = val[15:0];
                REG_DURATION: dur_ms = val;
                default: ;
            endcase
        endfunction

        function bit [15:0] axis_at(bit [15:0] s, bit [15:0] e, bit [47:0] el,
                                    bit [63:0] dur_us);
            int        delta;
            bit [63:0] mag, tpp, cur;
            delta = int'($signed(e)) - int'($signed(s));
            if (delta == 0) return s;
            mag = (delta < 0) ? 64'(-delta) : 64'(delta);
            tpp = dur_us / mag;
            if (tpp == 0) return e;
            cur = 64'(el) / tpp;
            return (delta < 0) ? s - cur[15:0] : s + cur[15:0];
        endfunction

        function void note_input(logic [MODE_BITS-1:0] mode, bit [47:0] now);
            t_pos_beat b;
            bit [47:0] el;
            bit [63:0] dur_us;
            b.valid = 0;
            b.x = 0;
            b.y = 0;
            dur_us = 64'(dur_ms) * US_PER_MS;
            if (mode == MODE_START) begin
                running = 1;
                t_begin = now;
                b.valid = 1;
                b.x = start_x;
                b.y = start_y;
            end else if (mode == MODE_STOP) begin
                running = 0;
            end else if (mode == MODE_TICK && running) begin
                el = now - t_begin;
                b.valid = 1;
                if (64'(el) >= dur_us) begin
                    b.x = end_x;
                    b.y = end_y;
                    running = 0;
                end else begin
                    b.x = axis_at(start_x, end_x, el, dur_us);
                    b.y = axis_at(start_y, end_y, el, dur_us);
                end
            end
            b.done = !running;
            pending.push_back(b);
        endfunction

        function void check_result(bit valid, bit [15:0] x, bit [15:0] y, bit done);
            t_pos_beat b;
            if (pending.size() == 0) begin
                $error("result beat with no pending expectation");
                errors++;
                return;
            end
            b = pending.pop_front();
            if (valid !== b.valid) begin
                $error("pos_valid expected %0d got %0d", b.valid, valid);
                errors++;
            end
            if (x !== b.x) begin
                $error("pos_x expected %0d got %0d", $signed(b.x), $signed(x));
                errors++;
            end
            if (y !== b.y) begin
                $error("pos_y expected %0d got %0d", $signed(b.y), $signed(y));
                errors++;
            end
            if (done !== b.done) begin
                $error("done_res expected %0d got %0d", b.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_s_tvalid = 1'b0;
    logic                     o_s_tready;
    logic [47:0]              i_s_tdata = '0;  // now_us
    logic [MODE_BITS-1:0]     i_s_tuser = '0;  // mode
    logic                     o_m_tvalid;
    logic                     i_m_tready = 1'b0;
    logic [31:0]              o_m_tdata;       // pos_x, pos_y
    logic                     o_m_tuser;       // pos_valid
    logic                     o_m_tlast;       // done_res

    move_scoreboard sb = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int sent_cnt = 0;

    linear_move_interpolator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
            i_m_tready = 1'b0;
        end else begin
            i_m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16], o_m_tlast);
    end

    function automatic bit [47:0] rand_time();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic bit [47:0] tick_offset(bit [63:0] dur_us);
        bit [63:0] r;
        int        sel;
        sel = $urandom_range(99);
        r = {$urandom, $urandom};
        if (sel < 70)
            r = r % (dur_us + dur_us / 4 + 2);
        else if (sel < 80)
            r = dur_us - $urandom_range(1, 0);
        return r[47:0];
    endfunction

    task automatic send_item(logic [MODE_BITS-1:0] mode, bit [47:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = mode;
        i_s_tdata = now;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(mode, now);
        sent_cnt++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_move(bit [15:0] sx, bit [15:0] sy, bit [15:0] ex, bit [15:0] ey,
                            bit [31:0] dur);
        bit [31:0] r;
        r = $urandom;
        write_reg(REG_START_X, {r[31:16], sx});
        write_reg(REG_START_Y, {r[15:0], sy});
        r = $urandom;
        write_reg(REG_END_X, {r[31:16], ex});
        write_reg(REG_END_Y, {r[15:0], ey});
        write_reg(REG_DURATION, dur);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic bit [15:0] rand_coord_pair(bit [15:0] s);
        int sel;
        sel = $urandom_range(2);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return s + 16'($urandom_range(600)) - 16'd300;
        return s;
    endfunction

    task automatic run_move(bit [63:0] dur_us);
        bit [47:0] t0;
        int        k;
        t0 = rand_time();
        send_item(MODE_START, t0);
        k = $urandom_range(1, 8);
        repeat (k) begin
            case ($urandom_range(19))
                0: send_item(MODE_STOP, t0 + tick_offset(dur_us));
                1: send_item(MODE_UNUSED, t0 + tick_offset(dur_us));
                2: send_item(MODE_START, t0 + tick_offset(dur_us));
                default: send_item(MODE_TICK, t0 + tick_offset(dur_us));
            endcase
        end
    endtask

    initial begin
        bit [47:0] t;
        bit [15:0] sx, sy, ex, ey;
        bit [31:0] dur;
        int        ph, base;
        bit        held, paused;
        held = 0;
        paused = 0;
        tx_idle_pct = 14;
        rx_idle_pct = 69;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // All registers at reset value: zero duration, zero coordinates.
        send_item(MODE_TICK, 48'h0);
        send_item(MODE_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_STOP, 48'h0);
        send_item(MODE_START, 48'hFFFF_FFFF_FFFF);
        send_item(MODE_UNUSED, 48'h1234_5678_9ABC);
        send_item(MODE_TICK, 48'h0);
        drain();

        set_move(16'h8000, 16'd100, 16'h7FFF, 16'd100, 32'hFFFF_FFFF);
        t = 48'hFFFF_FF00_0000;
        send_item(MODE_START, t);
        send_item(MODE_TICK, t + 48'd1_000_000_000_000);
        send_item(MODE_TICK, t);
        send_item(MODE_START, 48'h5);
        send_item(MODE_TICK, 48'h4);
        send_item(MODE_TICK, 48'h4);
        send_item(MODE_START, 48'h5555_5555_5555);
        send_item(MODE_STOP, 48'h5555_5555_5556);
        send_item(MODE_TICK, 48'h5555_5555_5557);
        drain();

        set_move(16'd0, 16'd0, 16'd5000, 16'hFFFD, 32'd1);
        t = 48'hAAAA_AAAA_AAAA;
        send_item(MODE_START, t);
        send_item(MODE_TICK, t + 48'd999);
        send_item(MODE_TICK, t + 48'd500);
        send_item(MODE_TICK, t + 48'd1000);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                tx_idle_pct = 69;
                rx_idle_pct = 14;
            end else if (ph == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sx = 16'($urandom);
            sy = 16'($urandom);
            ex = rand_coord_pair(sx);
            ey = rand_coord_pair(sy);
            dur = $urandom_range(1, 200);
            case (ph)
                0: begin
                    sx = 16'h8000;
                    ex = 16'h7FFF;
                    sy = 16'h7FFF;
                    ey = 16'h8000;
                    dur = $urandom_range(1, 100);
                end
                1: dur = 32'hFFFF_FFFF;
                2: dur = 32'd0;
                5: dur = $urandom;
                default: ;
            endcase
            set_move(sx, sy, ex, ey, dur);
            base = sent_cnt;
            while (sent_cnt - base < 190) begin
                if (ph == 3 && !held && sent_cnt - base >= 40) begin
                    hold_req++;
                    held = 1;
                end
                if (ph == 4 && !paused && sent_cnt - base >= 95) begin
                    drain();
                    paused = 1;
                end
                if ($urandom_range(99) < 85)
                    run_move(64'(dur) * US_PER_MS);
                else
                    send_item(2'($urandom_range(3)), rand_time());
            end
            drain();
        end

        repeat (250) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
